### src/mme_pkg.sv
package mme_pkg;

  // Element and fixed point format.
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;

  // Dimension registers.
  localparam int DIM_W = 4;
  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  // Saturation limits of a Q16.16 result.
  localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

endpackage

### src/matrix_multiply_engine.sv
// Dense matrix product C = A x B on signed Q16.16 elements.
// Configuration: cfg_index selects rows_a (0), inner_dim (1) or cols_b (2) and
// cfg_data gives the new 4-bit value; a write drops any partial load. A value
// of zero acts as one and a value above MAX_DIM acts as MAX_DIM.
// Input: elements of A and then of B, each in row-major order, one request
// per cycle while in_ready is high. in_ready stays low while C is computed.
// Output: C in row-major order, out_is_last set on its final element.
// Each result element passes in order through the read registers, the single
// shared 32x32 multiplier and the accumulator for inner_dim products, then a
// drain of that pipeline, a rounding step into q_r and saturation into the
// output register. Computing starts once the last element of B is accepted.
// The output register frees the datapath, so the next dot product starts
// while a result waits; if the receiver stalls, the sequencer holds the
// finished result before the output register until out_valid and out_ready
// meet. Reset returns the block to loading with all dimensions at 8 and
// nothing in the output register; the element stores are not cleared and
// need no clearing pass.
module matrix_multiply_engine #(
  parameter int MAX_DIM = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mme_pkg::DATA_W-1:0]   in_element_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mme_pkg::DATA_W-1:0]   out_product_value,
  output logic                                out_is_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mme_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]           cfg_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(2 * DEPTH + 1);
  localparam int DW     = mme_pkg::DATA_W;
  localparam int ACC_W  = 2 * DW + $clog2(MAX_DIM) + 1;
  localparam int Q_W    = ACC_W - mme_pkg::FRAC_W;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_EMIT
  } state_t;

  state_t                      state_r;
  logic [mme_pkg::DIM_W-1:0]   rows_r, inner_r, cols_r;
  logic [CNT_W-1:0]            load_cnt_r;
  logic [mme_pkg::DIM_W-1:0]   i_r, j_r, m_r;
  logic [ADDR_W-1:0]           a_base_r, a_addr_r, b_addr_r;
  logic                        iss_v_r, iss_first_r, mul_v_r, mul_first_r;
  logic signed [DW-1:0]        a_rd_r, b_rd_r;
  logic signed [2*DW-1:0]      prod_r;
  logic signed [ACC_W-1:0]     acc_r;
  logic [Q_W-1:0]              q_r;
  logic                        out_valid_r, out_last_r;
  logic [DW-1:0]               out_value_r;

  logic [DW-1:0] a_mem [DEPTH];
  logic [DW-1:0] b_mem [DEPTH];

  logic [mme_pkg::DIM_W-1:0] r_eff, k_eff, c_eff;
  logic [CNT_W-1:0]          a_len, total, load_idx, b_off;
  logic                      in_acc, wr_a, load_done, last_elem;
  logic                      cfg_hit, emit_go;
  logic [ACC_W-1:0]          round_sum;
  logic [DW-1:0]             sat_value;

  // Out-of-range dimensions are clamped to one and MAX_DIM.
  function automatic logic [mme_pkg::DIM_W-1:0] eff_dim(input logic [mme_pkg::DIM_W-1:0] v);
    logic [mme_pkg::DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = mme_pkg::DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      res = mme_pkg::DIM_W'(MAX_DIM);
    end
    return res;
  endfunction

  // Load addressing: A fills first, B follows.
  always_comb begin
    r_eff     = eff_dim(rows_r);
    k_eff     = eff_dim(inner_r);
    c_eff     = eff_dim(cols_r);
    a_len     = CNT_W'(r_eff) * CNT_W'(k_eff);
    total     = a_len + CNT_W'(k_eff) * CNT_W'(c_eff);
    load_idx  = (load_cnt_r >= total) ? '0 : load_cnt_r;
    b_off     = load_idx - a_len;
    in_acc    = in_valid && in_ready;
    wr_a      = load_idx < a_len;
    load_done = (load_idx + CNT_W'(1)) == total;
    cfg_hit   = cfg_valid && cfg_ready &&
                ((cfg_index == mme_pkg::REG_ROWS_A) ||
                 (cfg_index == mme_pkg::REG_INNER_DIM) ||
                 (cfg_index == mme_pkg::REG_COLS_B));
    emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  end

  // Rounding to Q16.16 and saturation to 32 bits.
  always_comb begin
    round_sum = acc_r + ACC_W'(1 << (mme_pkg::FRAC_W - 1));
    if ((&q_r[Q_W-1:DW-1]) || !(|q_r[Q_W-1:DW-1])) begin
      sat_value = q_r[DW-1:0];
    end else if (q_r[Q_W-1]) begin
      sat_value = mme_pkg::Q_MIN;
    end else begin
      sat_value = mme_pkg::Q_MAX;
    end
    last_elem = (i_r == r_eff - 1'b1) && (j_r == c_eff - 1'b1);
  end

  // Element store of A.
  always_ff @(posedge clk) begin
    if (in_acc && wr_a) begin
      a_mem[load_idx[ADDR_W-1:0]] <= in_element_value;
    end
    a_rd_r <= a_mem[a_addr_r];
  end

  // Element store of B.
  always_ff @(posedge clk) begin
    if (in_acc && !wr_a) begin
      b_mem[b_off[ADDR_W-1:0]] <= in_element_value;
    end
    b_rd_r <= b_mem[b_addr_r];
  end

  // Sequencer, multiply-accumulate datapath and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      rows_r      <= mme_pkg::DIM_RESET;
      inner_r     <= mme_pkg::DIM_RESET;
      cols_r      <= mme_pkg::DIM_RESET;
      load_cnt_r  <= '0;
      iss_v_r     <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The multiplier and accumulator run behind the read stage.
      iss_v_r     <= (state_r == ST_RUN);
      mul_v_r     <= iss_v_r;
      mul_first_r <= iss_first_r;
      prod_r      <= a_rd_r * b_rd_r;
      if (mul_v_r) begin
        acc_r <= (mul_first_r ? '0 : acc_r) + ACC_W'(prod_r);
      end

      // The output register takes a finished result or empties on a request.
      if (emit_go) begin
        out_valid_r <= 1'b1;
        out_value_r <= sat_value;
        out_last_r  <= last_elem;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      // A register write drops a partial load.
      if (cfg_hit) begin
        load_cnt_r <= '0;
      end else if (in_acc) begin
        if (load_done) begin
          load_cnt_r <= '0;
        end else begin
          load_cnt_r <= load_idx + CNT_W'(1);
        end
      end

      case (state_r)
        ST_LOAD: begin
          if (in_acc && load_done) begin
            i_r      <= '0;
            j_r      <= '0;
            m_r      <= '0;
            a_base_r <= '0;
            a_addr_r <= '0;
            b_addr_r <= '0;
            state_r  <= ST_RUN;
          end
        end
        ST_RUN: begin
          // Issue one pair of reads for the current dot product.
          iss_first_r <= (m_r == '0);
          a_addr_r    <= a_addr_r + ADDR_W'(1);
          b_addr_r    <= b_addr_r + ADDR_W'(c_eff);
          m_r         <= m_r + 1'b1;
          if (m_r == k_eff - 1'b1) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!iss_v_r && !mul_v_r) begin
            state_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          q_r     <= round_sum[ACC_W-1:mme_pkg::FRAC_W];
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            m_r <= '0;
            if (j_r == c_eff - 1'b1) begin
              j_r      <= '0;
              b_addr_r <= '0;
              if (i_r == r_eff - 1'b1) begin
                state_r <= ST_LOAD;
              end else begin
                state_r  <= ST_RUN;
                i_r      <= i_r + 1'b1;
                a_base_r <= a_base_r + ADDR_W'(k_eff);
                a_addr_r <= a_base_r + ADDR_W'(k_eff);
              end
            end else begin
              state_r  <= ST_RUN;
              j_r      <= j_r + 1'b1;
              a_addr_r <= a_base_r;
              b_addr_r <= ADDR_W'(j_r + 1'b1);
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase

      // Dimension register writes.
      if (cfg_valid) begin
        case (cfg_index)
          mme_pkg::REG_ROWS_A: begin
            rows_r <= cfg_data;
          end
          mme_pkg::REG_INNER_DIM: begin
            inner_r <= cfg_data;
          end
          mme_pkg::REG_COLS_B: begin
            cols_r <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign in_ready          = (state_r == ST_LOAD);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_product_value = out_value_r;
  assign out_is_last       = out_last_r;

endmodule
